[design/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[design/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 decoder: byte-range constants and the decode result type.
// No dependencies; used by u8u16_decode, u8u16_out and the top level.
package u8u16_pkg;

    // Reset value of the replacement unit
    localparam logic [15:0] REPL_RESET     = 16'hFFFD;

    // Lead byte ranges
    localparam logic [7:0]  LEAD2_MIN      = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX      = 8'hDF;
    localparam logic [7:0]  LEAD3_MIN      = 8'hE0;
    localparam logic [7:0]  LEAD3_MAX      = 8'hEF;
    localparam logic [7:0]  LEAD3_SURR     = 8'hED;
    localparam logic [7:0]  LEAD4_MIN      = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX      = 8'hF4;

    // First continuation bounds
    localparam logic [7:0]  CONT_LO        = 8'h80;
    localparam logic [7:0]  CONT_HI        = 8'hBF;
    localparam logic [7:0]  CONT_LO_E0     = 8'hA0;
    localparam logic [7:0]  CONT_HI_ED     = 8'h9F;
    localparam logic [7:0]  CONT_LO_F0     = 8'h90;
    localparam logic [7:0]  CONT_HI_F4     = 8'h8F;

    // Surrogate pair construction
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [5:0]  HI_SURR_PREFIX = 6'b110110;
    localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;

    // Up to two result units decoded from one item
    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] unit0;
        logic        repl0;
        logic [15:0] unit1;
        logic        repl1;
        logic        eol;
    } dec_res_t;

endpackage

[design/u8u16_ifs.sv]
// Handshake interfaces for the decoder channels: input bytes, output units, config writes.
// No dependencies.
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_line;

    modport source (output valid, byte_in, end_of_line, input ready);
    modport sink   (input valid, byte_in, end_of_line, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        was_replaced;
    logic        run_last;
    logic        line_done;

    modport source (output valid, code_unit, was_replaced, run_last, line_done, input ready);
    modport sink   (input valid, code_unit, was_replaced, run_last, line_done, output ready);
endinterface

interface u8u16_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] replacement_unit;

    modport source (output valid, replacement_unit, input ready);
    modport sink   (input valid, replacement_unit, output ready);
endinterface

[design/u8u16_decode.sv]
// Sequence state and single-pass decode of one byte into up to two UTF-16 units.
// Depends on u8u16_pkg.
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          byte_val,
    input  logic                eol,
    input  logic [15:0]         repl_unit,
    output u8u16_pkg::dec_res_t res
);
    import u8u16_pkg::*;

    logic [1:0]  need_reg, need_next;
    logic [1:0]  seen_reg, seen_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic [20:0] acc_reg, acc_next;

    logic        pending_in;
    logic        cont_ok;
    logic [1:0]  seen_inc;
    logic [20:0] acc_ext;
    logic [20:0] surr_off;

    logic        lead_ascii;
    logic [1:0]  lead_need;
    logic [20:0] lead_acc;
    logic [7:0]  lead_lo;
    logic [7:0]  lead_hi;

    logic        emit_present;
    logic [15:0] emit_unit;

    // Continuation check and accumulation
    assign pending_in = (need_reg != 2'd0);
    assign cont_ok    = (seen_reg == 2'd0) ? (byte_val >= lo_reg && byte_val <= hi_reg)
                                           : (byte_val[7:6] == 2'b10);
    assign seen_inc   = seen_reg + 2'd1;
    assign acc_ext    = {acc_reg[14:0], byte_val[5:0]};
    assign surr_off   = acc_ext - SUPP_BASE;

    // Lead byte classification
    always_comb
    begin
        lead_ascii = ~byte_val[7];
        lead_need  = 2'd0;
        lead_acc   = '0;
        lead_lo    = CONT_LO;
        lead_hi    = CONT_HI;
        if (byte_val >= LEAD2_MIN && byte_val <= LEAD2_MAX)
        begin
            lead_need = 2'd1;
            lead_acc  = {16'd0, byte_val[4:0]};
        end
        else if (byte_val >= LEAD3_MIN && byte_val <= LEAD3_MAX)
        begin
            lead_need = 2'd2;
            lead_acc  = {17'd0, byte_val[3:0]};
            if (byte_val == LEAD3_MIN)
                lead_lo = CONT_LO_E0;
            if (byte_val == LEAD3_SURR)
                lead_hi = CONT_HI_ED;
        end
        else if (byte_val >= LEAD4_MIN && byte_val <= LEAD4_MAX)
        begin
            lead_need = 2'd3;
            lead_acc  = {18'd0, byte_val[2:0]};
            if (byte_val == LEAD4_MIN)
                lead_lo = CONT_LO_F0;
            if (byte_val == LEAD4_MAX)
                lead_hi = CONT_HI_F4;
        end
    end

    // Unit from a fresh lead: ASCII, bad lead, or line end inside a new sequence
    assign emit_present = lead_ascii || (lead_need == 2'd0) || eol;
    assign emit_unit    = lead_ascii ? {8'd0, byte_val} : repl_unit;

    // Results and next sequence state
    always_comb
    begin
        res       = '0;
        res.eol   = eol;
        need_next = 2'd0;
        seen_next = 2'd0;
        lo_next   = CONT_LO;
        hi_next   = CONT_HI;
        acc_next  = '0;
        if (pending_in && cont_ok)
        begin
            if (seen_inc == need_reg)
            begin
                // sequence complete
                if (acc_ext[20:16] != 5'd0)
                begin
                    res.cnt   = 2'd2;
                    res.unit0 = {HI_SURR_PREFIX, surr_off[19:10]};
                    res.unit1 = {LO_SURR_PREFIX, surr_off[9:0]};
                end
                else
                begin
                    res.cnt   = 2'd1;
                    res.unit0 = acc_ext[15:0];
                end
            end
            else if (eol)
            begin
                // line ends inside the sequence
                res.cnt   = 2'd1;
                res.unit0 = repl_unit;
                res.repl0 = 1'b1;
            end
            else
            begin
                need_next = need_reg;
                seen_next = seen_inc;
                lo_next   = lo_reg;
                hi_next   = hi_reg;
                acc_next  = acc_ext;
            end
        end
        else
        begin
            // broken sequence gives a replacement, then the byte starts over as a lead
            if (pending_in)
            begin
                res.cnt   = emit_present ? 2'd2 : 2'd1;
                res.unit0 = repl_unit;
                res.repl0 = 1'b1;
                res.unit1 = emit_unit;
                res.repl1 = ~lead_ascii;
            end
            else
            begin
                res.cnt   = emit_present ? 2'd1 : 2'd0;
                res.unit0 = emit_unit;
                res.repl0 = ~lead_ascii;
            end
            if (lead_need != 2'd0 && !eol)
            begin
                need_next = lead_need;
                lo_next   = lead_lo;
                hi_next   = lead_hi;
                acc_next  = lead_acc;
            end
        end
    end

    // Sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            seen_reg <= 2'd0;
            lo_reg   <= CONT_LO;
            hi_reg   <= CONT_HI;
            acc_reg  <= '0;
        end
        else if (advance)
        begin
            need_reg <= need_next;
            seen_reg <= seen_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

[design/u8u16_out.sv]
// Result register holding up to two units, shifted out one unit at a time as unit_ch takes them.
// Depends on u8u16_pkg and u8u16_ifs.
module u8u16_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u8u16_pkg::dec_res_t res,
    output logic                free,
    u8u16_unit_if.source        unit_ch
);
    import u8u16_pkg::*;

    logic [1:0]  cnt_reg;
    logic        idx_reg;
    logic [15:0] unit0_reg, unit1_reg;
    logic        repl0_reg, repl1_reg;
    logic        eol_reg;
    logic        last;

    // Current unit is the last one of its item
    assign last = idx_reg || (cnt_reg == 2'd1);
    assign free = (cnt_reg == 2'd0) || (unit_ch.ready && last);

    assign unit_ch.valid        = (cnt_reg != 2'd0);
    assign unit_ch.code_unit    = idx_reg ? unit1_reg : unit0_reg;
    assign unit_ch.was_replaced = idx_reg ? repl1_reg : repl0_reg;
    assign unit_ch.run_last     = last;
    assign unit_ch.line_done    = last && eol_reg;

    // Control: unit count and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= res.cnt;
            idx_reg <= 1'b0;
        end
        else if (unit_ch.valid && unit_ch.ready)
        begin
            if (last)
                cnt_reg <= 2'd0;
            else
                idx_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit0_reg <= res.unit0;
            unit1_reg <= res.unit1;
            repl0_reg <= res.repl0;
            repl1_reg <= res.repl1;
            eol_reg   <= res.eol;
        end
    end

endmodule

[design/utf8_to_utf16_decoder.sv]
// Channel      Dir  Payload
// byte_ch      in   byte_in[7:0], end_of_line
// unit_ch      out  code_unit[15:0], was_replaced, run_last, line_done
// cfg          in   replacement_unit[15:0]
//
// Path from byte accept to first unit: input register, then result register.
// Throughput: one byte per cycle while unit_ch is ready; a byte giving two units holds
// the result register until both are taken, so the output port (one unit per cycle) sets the rate.
// Reset clears sequence state and sets the replacement unit to U+FFFD.
// A stall on unit_ch backs up through the result and input registers to byte_ch.ready.
// Top level of the UTF-8 to UTF-16 decoder; depends on u8u16_pkg, u8u16_ifs,
// u8u16_decode, u8u16_out and assert_macros.svh.
`include "assert_macros.svh"

module utf8_to_utf16_decoder (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    byte_ch,
    u8u16_unit_if.source  unit_ch,
    u8u16_cfg_if.sink     cfg
);
    import u8u16_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eol_reg;
    logic [15:0] repl_reg;
    logic        out_free;
    logic        advance;
    dec_res_t    res;

    // Input register moves into the result register when it has room
    assign advance       = s1_valid_reg && out_free;
    assign byte_ch.ready = !s1_valid_reg || out_free;
    assign cfg.ready     = 1'b1;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_ch.valid && byte_ch.ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            s1_byte_reg <= byte_ch.byte_in;
            s1_eol_reg  <= byte_ch.end_of_line;
        end
    end

    // Replacement unit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= REPL_RESET;
        else if (cfg.valid && cfg.ready)
            repl_reg <= cfg.replacement_unit;
    end

    u8u16_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_val  (s1_byte_reg),
        .eol       (s1_eol_reg),
        .repl_unit (repl_reg),
        .res       (res)
    );

    u8u16_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .res     (res),
        .free    (out_free),
        .unit_ch (unit_ch)
    );

    // A line-end item always yields at least one unit
    `ASSERT_IMPL(a_eol_has_unit, clk, rst_n, advance && s1_eol_reg |=> unit_ch.valid, "line end item gave no unit")
    // line_done only on the last unit of an item
    `ASSERT_IMPL(a_done_is_last, clk, rst_n, unit_ch.valid && unit_ch.line_done |-> unit_ch.run_last, "line_done without run_last")
    // A decoded high surrogate is always followed by its low half
    `ASSERT_NEVER(a_lone_high_surr, clk, rst_n, unit_ch.valid && !unit_ch.was_replaced && unit_ch.code_unit[15:10] == HI_SURR_PREFIX && unit_ch.run_last, "high surrogate emitted as last unit")

endmodule

[sim/utf8_to_utf16_decoder_checker.sv]
`timescale 1ns / 100ps
// Checker for the UTF-8 to UTF-16 decoder: watches the byte, unit and config channels,
// predicts the code units of each accepted byte and compares them in order.
// Depends on u8u16_pkg and the channel interfaces in u8u16_ifs.
module utf8_to_utf16_decoder_checker (
    input  logic    clk,
    input  logic    rst_n,
    u8u16_byte_if   byte_ch,
    u8u16_unit_if   unit_ch,
    u8u16_cfg_if    cfg,
    output int      fail_count,
    output int      units_outstanding
);
    import u8u16_pkg::*;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    typedef struct packed {
        logic [15:0] code;
        logic        repl;
        logic        last_of_byte;
        logic        last_of_line;
    } unit_rec_t;

    // Predicted decoder state
    logic [15:0] repl_unit;
    logic [1:0]  cont_need;
    logic [1:0]  cont_seen;
    logic [7:0]  first_lo;
    logic [7:0]  first_hi;
    logic [20:0] code_bits;

    unit_rec_t   units_due [$];

    function automatic void drop_sequence();
        cont_need = 2'd0;
        cont_seen = 2'd0;
        first_lo  = CONT_LO;
        first_hi  = CONT_HI;
        code_bits = '0;
    endfunction

    // Works out the units caused by one byte and queues them
    function automatic void decode_byte(input logic [7:0] b, input logic eol);
        unit_rec_t   fresh [$];
        logic        relead;
        logic        open_seq;
        logic        fits;
        logic [20:0] cp;
        logic [20:0] off;
        relead   = 1'b0;
        open_seq = 1'b0;
        if (cont_need != 2'd0)
        begin
            if (cont_seen == 2'd0)
                fits = (b >= first_lo) && (b <= first_hi);
            else
                fits = (b[7:6] == 2'b10);
            if (fits)
            begin
                code_bits = {code_bits[14:0], b[5:0]};
                cont_seen = cont_seen + 2'd1;
                if (cont_seen == cont_need)
                begin
                    cp = code_bits;
                    if (cp >= SUPP_BASE)
                    begin
                        off = cp - SUPP_BASE;
                        fresh.insert(fresh.size(),
                                     unit_rec_t'{{HI_SURR_PREFIX, off[19:10]}, 1'b0, 1'b0, 1'b0});
                        fresh.insert(fresh.size(),
                                     unit_rec_t'{{LO_SURR_PREFIX, off[9:0]}, 1'b0, 1'b0, 1'b0});
                    end
                    else
                    begin
                        fresh.insert(fresh.size(), unit_rec_t'{cp[15:0], 1'b0, 1'b0, 1'b0});
                    end
                    drop_sequence();
                end
                else
                begin
                    open_seq = 1'b1;
                end
            end
            else
            begin
                // breaking byte: replace the subpart, then treat the byte as a lead
                fresh.insert(fresh.size(), unit_rec_t'{repl_unit, 1'b1, 1'b0, 1'b0});
                drop_sequence();
                relead = 1'b1;
            end
        end
        else
        begin
            relead = 1'b1;
        end

        if (relead)
        begin
            if (b < ASCII_LIMIT)
            begin
                fresh.insert(fresh.size(), unit_rec_t'{{8'h00, b}, 1'b0, 1'b0, 1'b0});
            end
            else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            begin
                cont_need = 2'd1;
                code_bits = {16'd0, b[4:0]};
                open_seq  = 1'b1;
            end
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            begin
                cont_need = 2'd2;
                code_bits = {17'd0, b[3:0]};
                if (b == LEAD3_MIN)
                    first_lo = CONT_LO_E0;
                if (b == LEAD3_SURR)
                    first_hi = CONT_HI_ED;
                open_seq  = 1'b1;
            end
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            begin
                cont_need = 2'd3;
                code_bits = {18'd0, b[2:0]};
                if (b == LEAD4_MIN)
                    first_lo = CONT_LO_F0;
                if (b == LEAD4_MAX)
                    first_hi = CONT_HI_F4;
                open_seq  = 1'b1;
            end
            else
            begin
                // stray continuation or forbidden lead
                fresh.insert(fresh.size(), unit_rec_t'{repl_unit, 1'b1, 1'b0, 1'b0});
            end
        end

        // line ends with a sequence still open
        if (eol && open_seq)
        begin
            fresh.insert(fresh.size(), unit_rec_t'{repl_unit, 1'b1, 1'b0, 1'b0});
            drop_sequence();
        end

        if (fresh.size() > 0)
        begin
            fresh[fresh.size() - 1].last_of_byte = 1'b1;
            fresh[fresh.size() - 1].last_of_line = eol;
        end
        foreach (fresh[i])
            units_due.insert(units_due.size(), fresh[i]);
    endfunction

    // Compare outgoing units first, then predict from accepted bytes and config writes
    always @(posedge clk or negedge rst_n)
    begin
        unit_rec_t want;
        if (!rst_n)
        begin
            repl_unit = REPL_RESET;
            drop_sequence();
            units_due.delete();
            fail_count = 0;
            units_outstanding = 0;
        end
        else
        begin
            if (unit_ch.valid && unit_ch.ready)
            begin
                if (units_due.size() == 0)
                begin
                    $display("%0t: unexpected unit %h (repl %b last %b done %b)", $time,
                             unit_ch.code_unit, unit_ch.was_replaced, unit_ch.run_last,
                             unit_ch.line_done);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = units_due.pop_front();
                    if (unit_ch.code_unit !== want.code)
                    begin
                        $display("%0t: code_unit expected %h actual %h", $time,
                                 want.code, unit_ch.code_unit);
                        fail_count = fail_count + 1;
                    end
                    if (unit_ch.was_replaced !== want.repl)
                    begin
                        $display("%0t: was_replaced expected %b actual %b", $time,
                                 want.repl, unit_ch.was_replaced);
                        fail_count = fail_count + 1;
                    end
                    if (unit_ch.run_last !== want.last_of_byte)
                    begin
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.last_of_byte, unit_ch.run_last);
                        fail_count = fail_count + 1;
                    end
                    if (unit_ch.line_done !== want.last_of_line)
                    begin
                        $display("%0t: line_done expected %b actual %b", $time,
                                 want.last_of_line, unit_ch.line_done);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.byte_in, byte_ch.end_of_line);

            if (cfg.valid && cfg.ready)
                repl_unit = cfg.replacement_unit;

            units_outstanding = units_due.size();
        end
    end

endmodule

[sim/utf8_to_utf16_decoder_test.sv]
`timescale 1ns / 100ps
// Testbench top for the UTF-8 to UTF-16 decoder: drives bytes, unit backpressure and
// replacement-unit writes, and reports the verdict from the checker's failure count.
// Depends on u8u16_ifs, the decoder RTL and utf8_to_utf16_decoder_checker.
module utf8_to_utf16_decoder_test;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BYTE_TARGET   = 1300;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 150;

    localparam logic [7:0] ODD_LEADS [8] =
        '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hFF};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   units_outstanding;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   hold_requests = 0;
    logic tx_quiet = 1'b0;

    u8u16_byte_if byte_ch ();
    u8u16_unit_if unit_ch ();
    u8u16_cfg_if  cfg ();

    utf8_to_utf16_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .unit_ch (unit_ch),
        .cfg     (cfg)
    );

    utf8_to_utf16_decoder_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_ch           (byte_ch),
        .unit_ch           (unit_ch),
        .cfg               (cfg),
        .fail_count        (fail_count),
        .units_outstanding (units_outstanding)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Unit sink: random stalls, quiet stretches, and long hold-offs on request
    initial
    begin
        int stall_left;
        int mode_left;
        int holds_served;
        logic rx_quiet;
        stall_left   = 0;
        mode_left    = 0;
        holds_served = 0;
        rx_quiet     = 1'b0;
        unit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                rx_quiet  = ($urandom_range(0, 9) < 3);
                mode_left = $urandom_range(50, 400);
            end
            else
            begin
                mode_left = mode_left - 1;
            end

            if (holds_served != hold_requests)
            begin
                holds_served  = holds_served + 1;
                unit_ch.ready <= 1'b0;
                stall_left    = HOLD_CYCLES;
            end
            else if (stall_left > 0)
            begin
                unit_ch.ready <= 1'b0;
                stall_left    = stall_left - 1;
            end
            else if (rx_quiet)
            begin
                unit_ch.ready <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    unit_ch.ready <= 1'b0;
                    stall_left    = stall_left - 1;
                end
                else
                begin
                    unit_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Offers one byte after an optional gap and waits for it to be taken
    task automatic offer_byte(input logic [7:0] b, input logic eol);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.byte_in     <= b;
        byte_ch.end_of_line <= eol;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // One line: end_of_line on the last byte
    task automatic send_line(input logic [7:0] seq [$]);
        foreach (seq[i])
            offer_byte(seq[i], i == seq.size() - 1);
    endtask

    // Mostly well-formed characters, some truncated, some noise and odd leads
    task automatic send_random_line();
        logic [7:0]  line [$];
        logic [7:0]  enc [$];
        logic [20:0] cp;
        logic [20:0] lo;
        logic [20:0] hi;
        int          kind;
        int          chars;
        chars = $urandom_range(1, 12);
        repeat (chars)
        begin
            enc.delete();
            kind = $urandom_range(0, 99);
            if (kind < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       begin lo = 21'h000000; hi = 21'h00007F; end
                    1:       begin lo = 21'h000080; hi = 21'h0007FF; end
                    2:       begin lo = 21'h000800; hi = 21'h00FFFF; end
                    default: begin lo = 21'h010000; hi = 21'h10FFFF; end
                endcase
                cp = 21'($urandom_range(hi, lo));
                if ($urandom_range(0, 6) == 0)
                    cp = $urandom_range(0, 1) ? lo : hi;
                if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
                    cp = cp ^ 21'h002000;
                if (cp < 21'h000080)
                begin
                    enc.insert(enc.size(), cp[7:0]);
                end
                else if (cp < 21'h000800)
                begin
                    enc.insert(enc.size(), {3'b110, cp[10:6]});
                    enc.insert(enc.size(), {2'b10, cp[5:0]});
                end
                else if (cp < 21'h010000)
                begin
                    enc.insert(enc.size(), {4'b1110, cp[15:12]});
                    enc.insert(enc.size(), {2'b10, cp[11:6]});
                    enc.insert(enc.size(), {2'b10, cp[5:0]});
                end
                else
                begin
                    enc.insert(enc.size(), {5'b11110, cp[20:18]});
                    enc.insert(enc.size(), {2'b10, cp[17:12]});
                    enc.insert(enc.size(), {2'b10, cp[11:6]});
                    enc.insert(enc.size(), {2'b10, cp[5:0]});
                end
                // truncated sequence
                if (kind >= 78 && enc.size() > 1)
                    repeat ($urandom_range(1, enc.size() - 1))
                        void'(enc.pop_back());
            end
            else if (kind < 95)
            begin
                enc.insert(enc.size(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                enc.insert(enc.size(), ODD_LEADS[$urandom_range(0, 7)]);
                enc.insert(enc.size(), 8'($urandom_range(8'h80, 8'hBF)));
            end
            foreach (enc[i])
                line.insert(line.size(), enc[i]);
        end
        send_line(line);
    endtask

    // Stop offering and wait until the block has nothing left in flight
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(negedge clk);
        while (units_outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [15:0] value);
        drain();
        cfg.valid            <= 1'b1;
        cfg.replacement_unit <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] repl_values [PHASES];
        int          stretch_start;
        int          phase_end;
        repl_values = '{16'h0000, 16'hFFFF, 16'($urandom), 16'hFFFD,
                        16'($urandom), 16'h8001};
        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_in      <= 8'h00;
        byte_ch.end_of_line  <= 1'b0;
        cfg.valid            <= 1'b0;
        cfg.replacement_unit <= 16'h0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset replacement unit
        send_line('{8'h00});
        send_line('{8'h7F});
        send_line('{8'hC2, 8'h80});
        send_line('{8'hE0, 8'h9F});               // below E0 range, then stray
        send_line('{8'hED, 8'h9F, 8'hBF});        // last code point before surrogates
        send_line('{8'hF0, 8'h90, 8'h80, 8'h80}); // first supplementary
        send_line('{8'hF4, 8'h8F, 8'hBF, 8'hBF}); // last code point
        send_line('{8'hF4, 8'h90});               // above F4 range, then stray
        send_line('{8'hC0, 8'hFF});               // forbidden leads
        send_line('{8'hE2, 8'h41});               // break by ASCII
        send_line('{8'hE2, 8'h82});               // line ends mid-sequence
        send_line('{8'hF0});                      // lead carrying the line end

        // Random phases, one replacement unit each
        for (int p = 0; p < PHASES; p++)
        begin
            write_repl(repl_values[p]);
            phase_end = ((p + 1) * BYTE_TARGET) / PHASES;
            if (p == 1 || p == 4)
            begin
                // sink holds off while bytes keep coming
                tx_quiet      = 1'b1;
                hold_requests = hold_requests + 1;
                stretch_start = bytes_sent;
                while (bytes_sent - stretch_start < 80)
                    send_random_line();
            end
            while (bytes_sent < phase_end)
            begin
                tx_quiet = ($urandom_range(0, 4) == 0);
                send_random_line();
            end
        end
        tx_quiet = 1'b0;

        drain();
        if (fail_count == 0 && units_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
